@@ sv/video_ram_access_port_assert.svh @@
// Assertion macros shared by the access port modules.
`ifndef VIDEO_RAM_ACCESS_PORT_ASSERT_SVH
`define VIDEO_RAM_ACCESS_PORT_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked only while out of reset.
`define VRAP_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define VRAP_ASSERT_ALL(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VRAP_ASSERT_RST(label, clk, rst_n, prop, msg)
`define VRAP_ASSERT_ALL(label, clk, prop, msg)
`endif

`endif

@@ sv/vrap_pkg.sv @@
`timescale 1ns / 1ps
package vrap_pkg;

    localparam int VRAP_ADDR_BITS = 16;
    localparam int WORD_W         = 16;
    localparam int REG_IDX_W      = 3;
    localparam int IN_TDATA_W     = 24;
    localparam int IN_TUSER_W     = 1;
    localparam int OUT_TDATA_W    = 16;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_POINTER   = 3'd0,
        REG_DATA      = 3'd1,
        REG_INCREMENT = 3'd2,
        REG_HBLANK    = 3'd3,
        REG_IRQ_ACK   = 3'd6
    } t_reg_idx;

    typedef enum logic {
        FUNC_READ  = 1'b0,
        FUNC_WRITE = 1'b1
    } t_func;

    // controller -> datapath
    typedef struct packed {
        logic exec;      // apply the accepted access to the registers/memory
        logic out_zero;  // load a zero result
        logic out_mem;   // load the registered memory word as result
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic mem_read;  // current beat is a read of the data register
    } t_dp_stat;

endpackage

@@ sv/vrap_dp.sv @@
`timescale 1ns / 1ps
`include "video_ram_access_port_assert.svh"
module vrap_dp
    import vrap_pkg::*;
#(
    parameter int ADDR_BITS = VRAP_ADDR_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  logic                 i_func,
    input  logic [REG_IDX_W-1:0] i_reg_index,
    input  logic [WORD_W-1:0]    i_write_data,
    output t_dp_stat             o_stat,
    output logic [WORD_W-1:0]    o_read_data
);

    logic [WORD_W-1:0] r_mem [2**ADDR_BITS];
    logic [WORD_W-1:0] r_rd;
    logic [WORD_W-1:0] r_ptr, n_ptr;
    logic [WORD_W-1:0] r_inc, n_inc;
    logic [WORD_W-1:0] r_hblank, n_hblank;
    logic [WORD_W-1:0] r_out;
    logic              w_is_write;
    logic              w_mem_we;
    logic [ADDR_BITS-1:0] w_addr;

    assign w_is_write = (i_func == FUNC_WRITE);
    assign w_addr     = r_ptr[ADDR_BITS-1:0];
    assign w_mem_we   = i_cmd.exec && w_is_write && (i_reg_index == REG_DATA);

    assign o_stat.mem_read = !w_is_write && (i_reg_index == REG_DATA);

    always_comb begin
        n_ptr    = r_ptr;
        n_inc    = r_inc;
        n_hblank = r_hblank;
        if (i_cmd.exec && w_is_write) begin
            unique case (i_reg_index)
                REG_POINTER:   n_ptr    = i_write_data;
                REG_DATA:      n_ptr    = r_ptr + r_inc;
                REG_INCREMENT: n_inc    = i_write_data;
                REG_HBLANK:    n_hblank = i_write_data;
                default: ;     // irq ack and spare indexes do nothing
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_inc    <= '0;
            r_hblank <= '0;
        end else begin
            r_ptr    <= n_ptr;
            r_inc    <= n_inc;
            r_hblank <= n_hblank;
        end
    end

    // single port RAM, registered read at the pointer
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_addr] <= i_write_data;
        end
        r_rd <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_zero) begin
            r_out <= '0;
        end else if (i_cmd.out_mem) begin
            r_out <= r_rd;
        end
    end

    assign o_read_data = r_out;

    `VRAP_ASSERT_RST(a_ptr_set, i_clk, i_rst_n,
        (i_cmd.exec && w_is_write && i_reg_index == REG_POINTER) |=> (r_ptr == $past(i_write_data)),
        "pointer not loaded by register 0 write")
    `VRAP_ASSERT_RST(a_ptr_inc, i_clk, i_rst_n,
        w_mem_we |=> (r_ptr == $past(r_ptr + r_inc)),
        "pointer not advanced after data write")
    `VRAP_ASSERT_RST(a_ptr_hold, i_clk, i_rst_n,
        !i_cmd.exec |=> $stable(r_ptr) && $stable(r_inc),
        "pointer registers moved without an access")

endmodule

@@ sv/vrap_ctrl.sv @@
`timescale 1ns / 1ps
`include "video_ram_access_port_assert.svh"
module vrap_ctrl
    import vrap_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    output logic     o_m_tvalid,
    input  logic     i_m_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_m_tvalid, n_m_tvalid;
    logic   w_accept;

    // a waiting result leaves in the same cycle as the next beat comes in
    assign o_s_tready = (r_state == S_IDLE) || ((r_state == S_OUT) && i_m_tready);
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) begin
                n_state = i_stat.mem_read ? S_READ : S_OUT;
            end
            S_READ: n_state = S_OUT;
            S_OUT: begin
                if (w_accept) begin
                    n_state = i_stat.mem_read ? S_READ : S_OUT;
                end else if (i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_m_tvalid = (n_state == S_OUT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    assign o_m_tvalid     = r_m_tvalid;
    assign o_cmd.exec     = w_accept;
    assign o_cmd.out_zero = w_accept && !i_stat.mem_read;
    assign o_cmd.out_mem  = (r_state == S_READ);

    `VRAP_ASSERT_RST(a_short_lat, i_clk, i_rst_n,
        (w_accept && !i_stat.mem_read) |=> o_m_tvalid,
        "result missing one cycle after non-data-read beat")
    `VRAP_ASSERT_RST(a_read_lat, i_clk, i_rst_n,
        (w_accept && i_stat.mem_read) |=> !o_m_tvalid ##1 o_m_tvalid,
        "data read result not two cycles after accept")
    `VRAP_ASSERT_RST(a_valid_state, i_clk, i_rst_n,
        o_m_tvalid == (r_state == S_OUT),
        "output valid disagrees with state")

endmodule

@@ sv/video_ram_access_port.sv @@
`timescale 1ns / 1ps
// Auto-increment video RAM access port.
// Slave stream: one beat per host register access. tuser carries the access kind
// (0 read, 1 write), tdata the register index and the write word. Master stream: one
// beat per access, carrying the read word (zero for writes and for reads of any
// register other than the data register).
// Register 0 loads the address pointer, a write to register 1 stores a word at the
// pointer and then adds the increment (16-bit wrap), register 2 loads the increment,
// register 3 the hblank count; other indexes are ignored.
// Result valid in the cycle after accept; a data-register read first passes through
// the S_READ state, as the memory read port is registered. One access is in flight at a
// time; the next beat is taken in the cycle the result is taken, and tready is low
// while the word is fetched for a data-register read.
// Reset clears pointer, increment and hblank count; memory contents stay undefined
// until written and no clearing pass runs.
// When the sink stalls the result is held and no new beat is accepted.
module video_ram_access_port
    import vrap_pkg::*;
#(
    parameter int ADDR_BITS = VRAP_ADDR_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // reg_index[2:0], write_data[18:3], zero pad
    input  logic [IN_TUSER_W-1:0]  i_s_tuser,   // func[0]
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata    // read_data[15:0]
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    vrap_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    vrap_dp #(
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_func       (i_s_tuser[0]),
        .i_reg_index  (i_s_tdata[REG_IDX_W-1:0]),
        .i_write_data (i_s_tdata[REG_IDX_W+WORD_W-1:REG_IDX_W]),
        .o_stat       (w_stat),
        .o_read_data  (o_m_tdata)
    );

endmodule

@@ dv/video_ram_access_port_checker.sv @@
`timescale 1ns / 1ps
module video_ram_access_port_checker
    import vrap_pkg::*;
#(
    parameter int ADDR_BITS = VRAP_ADDR_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // reg_index[2:0], write_data[18:3], zero pad
    input  logic [IN_TUSER_W-1:0]  i_s_tuser,   // func[0]
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,   // read_data[15:0]
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked
);

    localparam int MEM_WORDS = 1 << ADDR_BITS;

    logic [WORD_W-1:0] vram_shadow [0:MEM_WORDS-1];
    logic [WORD_W-1:0] ptr_shadow;
    logic [WORD_W-1:0] incr_shadow;
    logic [WORD_W-1:0] hblank_shadow;
    logic [WORD_W-1:0] read_word_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        for (int i = 0; i < MEM_WORDS; i++) vram_shadow[i] = '0;
    end

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] want,
                                   input logic [WORD_W-1:0] got);
        $display("[%0t] MISMATCH %s: expected %h, got %h", $realtime, what, want, got);
        o_fail_count++;
    endtask

    // Applies one access to the shadow state and returns the word the port should give back.
    function automatic logic [WORD_W-1:0] access_word(input t_func kind,
                                                      input logic [REG_IDX_W-1:0] ridx,
                                                      input logic [WORD_W-1:0] wdata);
        logic [ADDR_BITS-1:0] widx;
        logic [WORD_W-1:0]    word;
        widx = ptr_shadow[ADDR_BITS-1:0];
        word = '0;
        if (kind == FUNC_WRITE) begin
            case (ridx)
                REG_POINTER:   ptr_shadow = wdata;
                REG_DATA: begin
                    vram_shadow[widx] = wdata;
                    ptr_shadow        = ptr_shadow + incr_shadow;   // 16-bit wrap
                end
                REG_INCREMENT: incr_shadow = wdata;
                REG_HBLANK:    hblank_shadow = wdata;
                default: ;
            endcase
        end else if (ridx == REG_DATA) begin
            word = vram_shadow[widx];
        end
        return word;
    endfunction

    always @(posedge i_clk) begin
        logic [WORD_W-1:0] want;
        if (!i_rst_n) begin
            ptr_shadow    = '0;
            incr_shadow   = '0;
            hblank_shadow = '0;
            read_word_q.delete();
        end else begin
            // result side first: a result never belongs to the beat taken at the same edge
            if (i_m_tvalid && i_m_tready) begin
                if (read_word_q.size() == 0) begin
                    report_mismatch("unexpected result beat", '0, i_m_tdata);
                end else begin
                    want = read_word_q.pop_front();
                    if (i_m_tdata !== want) report_mismatch("read_data", want, i_m_tdata);
                    o_checked++;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                read_word_q.push_back(access_word(t_func'(i_s_tuser[0]),
                                                  i_s_tdata[REG_IDX_W-1:0],
                                                  i_s_tdata[REG_IDX_W +: WORD_W]));
            end
        end
        o_pending <= read_word_q.size();
    end

endmodule

@@ dv/video_ram_access_port_tb.sv @@
`timescale 1ns / 1ps
module video_ram_access_port_tb;
    import vrap_pkg::*;

    localparam int                   MEM_WORDS  = 1 << VRAP_ADDR_BITS;
    localparam int                   RAND_BEATS = 550;
    localparam int                   LONG_HOLD  = 300;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_4 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_5 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int checked;

    // stimulus-side bookkeeping, only to keep reads on written words
    logic [WORD_W-1:0] stim_ptr = '0;
    logic [WORD_W-1:0] stim_incr = '0;
    bit                word_written [0:MEM_WORDS-1];
    logic [WORD_W-1:0] written_list [$];

    int n_sent = 0;
    int n_directed = 0;
    int n_readback = 0;
    int calm_left = 0;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", pending);
        $display("CHECKS FAILED");
        $finish;
    end

    video_ram_access_port u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    video_ram_access_port_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // result sink: random stall bursts, stretches of no stalls, one long hold-off on request
    initial begin
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(10, 60)) @(posedge clk);
            end else begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic send_access(input t_func kind, input logic [REG_IDX_W-1:0] ridx,
                               input logic [WORD_W-1:0] wdata);
        int                        gap;
        logic [VRAP_ADDR_BITS-1:0] widx;
        widx = stim_ptr[VRAP_ADDR_BITS-1:0];
        // never read a word that was not written
        if (kind == FUNC_READ && ridx == REG_DATA && !word_written[widx])
            ridx = REG_IDX_W'($urandom_range(2, 7));
        gap = 0;
        if (quiet || calm_left > 0) begin
            if (calm_left > 0) calm_left--;
        end else if ($urandom_range(0, 19) == 0) begin
            calm_left = $urandom_range(20, 60);
        end else if ($urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 18);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - REG_IDX_W - WORD_W){1'b0}}, wdata, ridx};
        s_tuser  <= kind;
        do @(posedge clk); while (!s_tready);
        n_sent++;
        if (kind == FUNC_WRITE) begin
            case (ridx)
                REG_POINTER:   stim_ptr = wdata;
                REG_DATA: begin
                    if (!word_written[widx]) begin
                        word_written[widx] = 1'b1;
                        if (written_list.size() < 512) written_list.push_back(widx);
                        else written_list[$urandom_range(0, 511)] = widx;
                    end
                    stim_ptr = stim_ptr + stim_incr;
                end
                REG_INCREMENT: stim_incr = wdata;
                default: ;
            endcase
        end else if (ridx == REG_DATA) begin
            n_readback++;
        end
    endtask

    // drop valid and hold until every outstanding result has been taken
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial begin
        int               n_rand;
        int               n0;
        int               burst;
        bit               hold_asked;
        bit               paused;
        logic [WORD_W-1:0] addr;
        n_rand     = 0;
        hold_asked = 1'b0;
        paused     = 1'b0;
        for (int i = 0; i < MEM_WORDS; i++) word_written[i] = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reads of every register but data return zero
        send_access(FUNC_READ, REG_POINTER, 16'hFFFF);
        send_access(FUNC_READ, REG_INCREMENT, 16'h0000);
        send_access(FUNC_READ, REG_HBLANK, 16'hAAAA);
        send_access(FUNC_READ, REG_SPARE_4, 16'h5555);
        send_access(FUNC_READ, REG_SPARE_5, 16'hFFFF);
        send_access(FUNC_READ, REG_IRQ_ACK, 16'h0000);
        send_access(FUNC_READ, REG_SPARE_7, 16'hFFFF);
        // hblank latch, interrupt acknowledge and spare writes leave memory and pointer alone
        send_access(FUNC_WRITE, REG_HBLANK, 16'hFFFF);
        send_access(FUNC_WRITE, REG_IRQ_ACK, 16'hAAAA);
        send_access(FUNC_WRITE, REG_SPARE_4, 16'h5555);
        send_access(FUNC_WRITE, REG_SPARE_5, 16'hFFFF);
        send_access(FUNC_WRITE, REG_SPARE_7, 16'h0000);
        // zero increment: pointer stays on the top word
        send_access(FUNC_WRITE, REG_POINTER, 16'hFFFF);
        send_access(FUNC_WRITE, REG_DATA, 16'hFFFF);
        send_access(FUNC_READ, REG_DATA, 16'h0000);
        // increment of one wraps the pointer from the top word to zero
        send_access(FUNC_WRITE, REG_INCREMENT, 16'h0001);
        send_access(FUNC_WRITE, REG_DATA, 16'h0000);
        send_access(FUNC_WRITE, REG_DATA, 16'h1234);
        send_access(FUNC_WRITE, REG_POINTER, 16'h0000);
        send_access(FUNC_READ, REG_DATA, 16'hFFFF);
        send_access(FUNC_WRITE, REG_POINTER, 16'hFFFF);
        send_access(FUNC_READ, REG_DATA, 16'h5555);
        // all-ones increment steps backwards
        send_access(FUNC_WRITE, REG_INCREMENT, 16'hFFFF);
        send_access(FUNC_WRITE, REG_DATA, 16'hA5A5);
        send_access(FUNC_WRITE, REG_DATA, 16'h5A5A);
        n_directed = n_sent;

        while (n_rand < RAND_BEATS) begin
            n0 = n_sent;
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    case ($urandom_range(0, 3))
                        0: addr = WORD_W'($urandom_range(0, 31));
                        1: addr = 16'hFFFF - WORD_W'($urandom_range(0, 15));
                        2: addr = 16'h8000 + WORD_W'($urandom_range(0, 31));
                        default: addr = WORD_W'($urandom);
                    endcase
                    send_access(FUNC_WRITE, REG_POINTER, addr);
                    case ($urandom_range(0, 4))
                        0: addr = 16'h0000;
                        1: addr = 16'h0001;
                        2: addr = 16'hFFFF;
                        3: addr = WORD_W'($urandom_range(2, 7));
                        default: addr = WORD_W'($urandom);
                    endcase
                    send_access(FUNC_WRITE, REG_INCREMENT, addr);
                    burst = $urandom_range(1, 8);
                    repeat (burst) send_access(FUNC_WRITE, REG_DATA, WORD_W'($urandom));
                end
                3, 4, 5: begin
                    burst = $urandom_range(1, 6);
                    repeat (burst) begin
                        addr = written_list[$urandom_range(0, written_list.size() - 1)];
                        send_access(FUNC_WRITE, REG_POINTER, addr);
                        send_access(FUNC_READ, REG_DATA, WORD_W'($urandom));
                        if ($urandom_range(0, 2) == 0)
                            send_access(FUNC_READ, REG_DATA, WORD_W'($urandom));
                    end
                end
                6, 7: begin
                    send_access(t_func'($urandom_range(0, 1)), REG_IDX_W'($urandom_range(0, 7)),
                                WORD_W'($urandom));
                end
                8: begin
                    // pointer moved then left pointing anywhere; read is guarded
                    send_access(FUNC_WRITE, REG_POINTER, WORD_W'($urandom));
                    send_access(FUNC_READ, REG_DATA, WORD_W'($urandom));
                    send_access(FUNC_WRITE, REG_HBLANK, WORD_W'($urandom));
                end
                default: begin
                    // overwrite in place with a zero increment, then read it back
                    addr = written_list[$urandom_range(0, written_list.size() - 1)];
                    send_access(FUNC_WRITE, REG_POINTER, addr);
                    send_access(FUNC_WRITE, REG_INCREMENT, 16'h0000);
                    send_access(FUNC_WRITE, REG_DATA, WORD_W'($urandom));
                    send_access(FUNC_READ, REG_DATA, WORD_W'($urandom));
                end
            endcase
            n_rand += n_sent - n0;
            if (!hold_asked && n_rand >= 150) begin
                hold_req   = 1'b1;
                hold_asked = 1'b1;
            end
            if (!paused && n_rand >= 300) begin
                wait_drained();
                paused = 1'b1;
            end
            if (n_rand >= RAND_BEATS - 80) quiet = 1'b1;
        end

        wait_drained();
        repeat (10) @(posedge clk);
        $display("Sent %0d accesses (%0d directed), %0d results compared", n_sent, n_directed,
                 checked);
        $display("Data-register read-backs: %0d, with pointer wrap, zero and negative steps",
                 n_readback);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
